// ----- src/olad_pkg.sv -----
package olad_pkg;

	localparam int CAPACITY_DEF   = 16;
	localparam int DATA_WIDTH_DEF = 32;
	localparam int CMD_W          = 2;
	localparam int STATUS_W       = 3;

	// command codes; code 3 is unused and ignored
	localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
	localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_LIST   = 2'd2;

	typedef enum logic [STATUS_W-1:0] {
		ST_INSERTED  = 3'd0,
		ST_DELETED   = 3'd1,
		ST_NOT_FOUND = 3'd2,
		ST_EMPTY     = 3'd3,
		ST_FULL      = 3'd4,
		ST_LISTED    = 3'd5
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_APPEND,
		S_SEARCH,
		S_SHIFT,
		S_LIST,
		S_REP_INS,
		S_REP_FULL,
		S_REP_DEL,
		S_REP_NF,
		S_REP_EMPTY
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic    accept;
		logic    issue;
		logic    hold;
		logic    wr_append;
		logic    wr_shift;
		logic    cnt_inc;
		logic    cnt_dec;
		logic    clr_val;
		logic    out_load;
		logic    out_last;
		logic    out_from_mem;
		status_t out_status;
	} ctl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [CMD_W-1:0] in_cmd;
		logic             cnt_zero;
		logic             full;
		logic             rp_lt_cnt;
		logic             rv;
		logic             match;
		logic             ri_last;
		logic             out_free;
	} ctl_sts_t;

endpackage

// ----- src/olad_ctrl.sv -----
module olad_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  olad_pkg::ctl_sts_t sts,
	output olad_pkg::ctl_cmd_t cmd
);

	olad_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= olad_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			olad_pkg::S_IDLE: begin
				if (s_tvalid) begin
					priority if (sts.in_cmd == olad_pkg::CMD_APPEND) begin
						state_d = olad_pkg::S_APPEND;
					end else if (sts.in_cmd == olad_pkg::CMD_DELETE) begin
						state_d = sts.cnt_zero ? olad_pkg::S_REP_EMPTY : olad_pkg::S_SEARCH;
					end else if (sts.in_cmd == olad_pkg::CMD_LIST) begin
						state_d = sts.cnt_zero ? olad_pkg::S_REP_EMPTY : olad_pkg::S_LIST;
					end else begin
						state_d = olad_pkg::S_IDLE;
					end
				end
			end
			olad_pkg::S_APPEND: begin
				state_d = sts.full ? olad_pkg::S_REP_FULL : olad_pkg::S_REP_INS;
			end
			olad_pkg::S_SEARCH: begin
				if (sts.rv && sts.match) begin
					state_d = sts.ri_last ? olad_pkg::S_REP_DEL : olad_pkg::S_SHIFT;
				end else if (sts.rv && sts.ri_last) begin
					state_d = olad_pkg::S_REP_NF;
				end
			end
			olad_pkg::S_SHIFT: begin
				if (sts.rv && sts.ri_last) begin
					state_d = olad_pkg::S_REP_DEL;
				end
			end
			olad_pkg::S_LIST: begin
				if (sts.rv && sts.out_free && sts.ri_last) begin
					state_d = olad_pkg::S_IDLE;
				end
			end
			olad_pkg::S_REP_INS, olad_pkg::S_REP_FULL, olad_pkg::S_REP_DEL,
			olad_pkg::S_REP_NF, olad_pkg::S_REP_EMPTY: begin
				if (sts.out_free) begin
					state_d = olad_pkg::S_IDLE;
				end
			end
			default: state_d = olad_pkg::S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd              = '0;
		cmd.out_status   = olad_pkg::ST_INSERTED;
		s_tready         = 1'b0;
		unique case (state_q)
			olad_pkg::S_IDLE: begin
				s_tready   = 1'b1;
				cmd.accept = s_tvalid;
				// an empty listing reports element zero
				cmd.clr_val = s_tvalid && sts.cnt_zero && (sts.in_cmd == olad_pkg::CMD_LIST);
			end
			olad_pkg::S_APPEND: begin
				cmd.wr_append = !sts.full;
				cmd.cnt_inc   = !sts.full;
			end
			olad_pkg::S_SEARCH: begin
				cmd.issue   = sts.rp_lt_cnt;
				cmd.cnt_dec = sts.rv && sts.match && sts.ri_last;
			end
			olad_pkg::S_SHIFT: begin
				cmd.issue    = sts.rp_lt_cnt;
				cmd.wr_shift = sts.rv;
				cmd.cnt_dec  = sts.rv && sts.ri_last;
			end
			olad_pkg::S_LIST: begin
				cmd.out_status   = olad_pkg::ST_LISTED;
				cmd.out_from_mem = 1'b1;
				cmd.out_last     = sts.ri_last;
				if (!sts.rv) begin
					cmd.issue = sts.rp_lt_cnt;
				end else if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.issue    = sts.rp_lt_cnt;
				end else begin
					cmd.hold = 1'b1;
				end
			end
			olad_pkg::S_REP_INS: begin
				cmd.out_load   = sts.out_free;
				cmd.out_last   = 1'b1;
				cmd.out_status = olad_pkg::ST_INSERTED;
			end
			olad_pkg::S_REP_FULL: begin
				cmd.out_load   = sts.out_free;
				cmd.out_last   = 1'b1;
				cmd.out_status = olad_pkg::ST_FULL;
			end
			olad_pkg::S_REP_DEL: begin
				cmd.out_load   = sts.out_free;
				cmd.out_last   = 1'b1;
				cmd.out_status = olad_pkg::ST_DELETED;
			end
			olad_pkg::S_REP_NF: begin
				cmd.out_load   = sts.out_free;
				cmd.out_last   = 1'b1;
				cmd.out_status = olad_pkg::ST_NOT_FOUND;
			end
			olad_pkg::S_REP_EMPTY: begin
				cmd.out_load   = sts.out_free;
				cmd.out_last   = 1'b1;
				cmd.out_status = olad_pkg::ST_EMPTY;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("result loaded while output register busy");

	a_issue_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> sts.rp_lt_cnt)
		else $error("entry read issued past the tail");

endmodule

// ----- src/olad_dpath.sv -----
module olad_dpath #(
	parameter int CAPACITY   = olad_pkg::CAPACITY_DEF,
	parameter int DATA_WIDTH = olad_pkg::DATA_WIDTH_DEF,
	parameter int IN_W       = 40,
	parameter int OUT_W      = 40
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [IN_W-1:0]    s_tdata,
	input  olad_pkg::ctl_cmd_t cmd,
	output olad_pkg::ctl_sts_t sts,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [OUT_W-1:0]   m_tdata,
	output logic               m_tlast
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	logic [DATA_WIDTH-1:0] entries_q [CAPACITY];
	logic [DATA_WIDTH-1:0] val_q;
	logic [CW-1:0]         cnt_q;
	logic [CW-1:0]         rp_q;
	logic [CW-1:0]         ri_s1;
	logic [CW-1:0]         ri_dec;
	logic [DATA_WIDTH-1:0] rdata_s1;
	logic                  rv_s1;

	logic                      ov_q;
	logic                      olast_q;
	olad_pkg::status_t         ostat_q;
	logic [DATA_WIDTH-1:0]     oelem_q;
	logic [CW-1:0]             ocnt_q;

	assign ri_dec = ri_s1 - CW'(1);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rp_q  <= '0;
			rv_s1 <= 1'b0;
			ov_q  <= 1'b0;
		end else begin
			if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (cmd.cnt_dec) begin
				cnt_q <= cnt_q - CW'(1);
			end
			if (cmd.accept) begin
				rp_q <= '0;
			end else if (cmd.issue) begin
				rp_q <= rp_q + CW'(1);
			end
			rv_s1 <= cmd.issue | (rv_s1 & cmd.hold);
			ov_q  <= cmd.out_load | (ov_q & !m_tready);
		end
	end

	// request value
	always_ff @(posedge clk) begin
		if (cmd.clr_val) begin
			val_q <= '0;
		end else if (cmd.accept) begin
			val_q <= s_tdata[olad_pkg::CMD_W +: DATA_WIDTH];
		end
	end

	// entry memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (cmd.wr_append) begin
			entries_q[cnt_q[AW-1:0]] <= val_q;
		end else if (cmd.wr_shift) begin
			entries_q[ri_dec[AW-1:0]] <= rdata_s1;
		end
		if (cmd.issue) begin
			rdata_s1 <= entries_q[rp_q[AW-1:0]];
			ri_s1    <= rp_q;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			olast_q <= cmd.out_last;
			ostat_q <= cmd.out_status;
			oelem_q <= cmd.out_from_mem ? rdata_s1 : val_q;
			ocnt_q  <= cnt_q;
		end
	end

	assign m_tvalid = ov_q;
	assign m_tlast  = olast_q;
	assign m_tdata  = OUT_W'({ocnt_q, oelem_q, ostat_q});

	assign sts.in_cmd    = s_tdata[olad_pkg::CMD_W-1:0];
	assign sts.cnt_zero  = (cnt_q == '0);
	assign sts.full      = (cnt_q == CW'(CAPACITY));
	assign sts.rp_lt_cnt = (rp_q < cnt_q);
	assign sts.rv        = rv_s1;
	assign sts.match     = (rdata_s1 == val_q);
	assign sts.ri_last   = ((ri_s1 + CW'(1)) == cnt_q);
	assign sts.out_free  = !ov_q || m_tready;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_shift_addr: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_shift |-> (ri_s1 != '0) && rv_s1)
		else $error("compaction write without a valid source entry");

	a_append_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_append |=> (cnt_q == $past(cnt_q) + CW'(1)))
		else $error("append did not grow the list");

endmodule

// ----- src/ordered_list_append_delete.sv -----
// Ordered list of up to CAPACITY signed DATA_WIDTH-bit values held in a
// compacted entry memory with a count. A request carries a command and a
// value: append stores the value after the tail (status full if there is no
// room), delete removes the first entry from the head that equals the value
// and closes the gap (status not found or empty otherwise), and list streams
// every entry from head to tail with tlast on the tail entry, or a single
// empty status with element zero. Every result carries the entry count after
// the request; command code 3 is taken and ignored with no result. Requests
// are handled one at a time: a new request is taken only when the previous
// one has handed its last result to the output register, which may still be
// waiting for m_tready. Append passes an append and a report state; delete
// or list of an empty list goes straight to its report. Delete searches from
// the head and compacts the entries behind a match before reporting. Search,
// compaction and listing use the single read port, one entry per cycle, with
// listing held while output is busy. No clearing pass is needed after reset.
module ordered_list_append_delete #(
	parameter int CAPACITY   = olad_pkg::CAPACITY_DEF,
	parameter int DATA_WIDTH = olad_pkg::DATA_WIDTH_DEF,
	localparam int CW        = $clog2(CAPACITY + 1),
	localparam int IN_W      = ((olad_pkg::CMD_W + DATA_WIDTH + 7) / 8) * 8,
	localparam int OUT_W     = ((olad_pkg::STATUS_W + DATA_WIDTH + CW + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,   // command, value, zero fill
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata,   // status, element, count, zero fill
	output logic             m_tlast    // final result of the request
);

	olad_pkg::ctl_cmd_t cmd;
	olad_pkg::ctl_sts_t sts;

	// sequencing of append, search, compaction, listing and reports
	olad_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// entry memory, count, read pipeline and output register
	olad_dpath #(
		.CAPACITY   (CAPACITY),
		.DATA_WIDTH (DATA_WIDTH),
		.IN_W       (IN_W),
		.OUT_W      (OUT_W)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.cmd      (cmd),
		.sts      (sts),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule
